>>> hdl/alpha_shape_bounds_measure_macros.svh
// Assertion macros for the alpha shape bounds measurement block.
// Used by the checker module; no other dependencies.
`ifndef ALPHA_SHAPE_BOUNDS_MEASURE_MACROS_SVH
`define ALPHA_SHAPE_BOUNDS_MEASURE_MACROS_SVH

// Clocked assertion, ignored while reset is held.
`define ASBM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Clocked assertion that also holds through reset.
`define ASBM_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

>>> hdl/asbm_pkg.sv
// Shared constants for the alpha shape bounds measurement block.
// Field widths, fixed-point constants and stream packing offsets; no dependencies.
package asbm_pkg;

    localparam int DEF_MAX_ROWS    = 8192;
    localparam int DEF_MAX_COLUMNS = 8192;

    // input record fields
    localparam int FIRST_W      = 14;
    localparam int COL_W        = 13;
    localparam int ALPHA_W      = 17;
    localparam int AREA_IN_W    = 22;
    localparam int OUTLINE_IN_W = 23;
    localparam int COL_MAX_IN   = 8191;

    // result fields
    localparam int EDGE_W    = 31;
    localparam int AREA_W    = 34;
    localparam int OUTLINE_W = 35;

    // 1/65536 fixed point
    localparam int FRAC_BITS = 16;
    localparam int ONE_FX    = 65536;
    localparam int HALF_FX   = 32768;

    // input tdata layout
    localparam int IN_TDATA_W   = 128;
    localparam int IN_FIRST_LSB = 0;
    localparam int IN_LAST_LSB  = IN_FIRST_LSB + FIRST_W;
    localparam int IN_AF_LSB    = IN_LAST_LSB + COL_W;
    localparam int IN_AL_LSB    = IN_AF_LSB + ALPHA_W;
    localparam int IN_AP_LSB    = IN_AL_LSB + ALPHA_W;
    localparam int IN_AREA_LSB  = IN_AP_LSB + ALPHA_W;
    localparam int IN_OUTL_LSB  = IN_AREA_LSB + AREA_IN_W;

    // output tdata layout
    localparam int OUT_TDATA_W    = 200;
    localparam int OUT_LEFT_LSB   = 0;
    localparam int OUT_RIGHT_LSB  = OUT_LEFT_LSB + EDGE_W;
    localparam int OUT_TOP_LSB    = OUT_RIGHT_LSB + EDGE_W;
    localparam int OUT_BOTTOM_LSB = OUT_TOP_LSB + EDGE_W;
    localparam int OUT_AREA_LSB   = OUT_BOTTOM_LSB + EDGE_W;
    localparam int OUT_OUTL_LSB   = OUT_AREA_LSB + AREA_W;
    localparam int OUT_FIELDS_W   = OUT_OUTL_LSB + OUTLINE_W;
    localparam int OUT_USER_W     = 1;

endpackage

>>> hdl/alpha_shape_bounds_measure.sv
// Top level of the alpha shape bounds measurement block: row statistics in,
// one bounding box and totals out per frame. Depends on asbm_pkg.
//
//  channel  | direction | payload                                  | marker
//  ---------+-----------+------------------------------------------+----------------
//  s_axis   | in        | one row record per transaction           | tlast=last row
//  m_axis   | out       | box edges and totals, one per frame      | tuser=visible
//
// One row record is taken every cycle unless ready drops, as below. After the
// transaction carrying the last row, the row is registered on acceptance, the state
// update loads the raw edge register, and widening loads the output register, where the result is valid.
// Reset is synchronous, active low, and clears the pipeline valids and all
// frame state. A stalled result holds in the output register while rows keep
// flowing; ready drops only when a last row meets a full widening stage.
module alpha_shape_bounds_measure
    import asbm_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // row_first, row_last, alpha_at_first, alpha_at_last, alpha_peak,
    // row_area, row_outline, zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                   i_s_axis_tlast,   // last_row
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // edge_left, edge_right, edge_top, edge_bottom, total_area,
    // total_outline, zero pad
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic [OUT_USER_W-1:0]  o_m_axis_tuser    // visible
);

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(MAX_ROWS - 1);
    localparam int COL_LIM = (MAX_COLUMNS - 1 > COL_MAX_IN) ? COL_MAX_IN : MAX_COLUMNS - 1;
    localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(COL_LIM);
    localparam int POS_W = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int EW    = POS_W + ALPHA_W + 2;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(ONE_FX);
    localparam logic [EW-1:0] ONE_EW  = EW'(ONE_FX);
    localparam logic [EW-1:0] HALF_EW = EW'(HALF_FX);

    function automatic logic [ALPHA_W-1:0] clamp_alpha(input logic [ALPHA_W-1:0] a);
        return (a > ALPHA_ONE) ? ALPHA_ONE : a;
    endfunction

    function automatic logic [COL_W-1:0] clamp_col(input logic [COL_W-1:0] c);
        return (c > COL_LIMIT) ? COL_LIMIT : c;
    endfunction

    // spans thinner than a pixel become one pixel around their floored centre;
    // result is {lo, hi}
    function automatic logic [2*EW-1:0] widen(input logic [EW-1:0] lo,
                                              input logic [EW-1:0] hi);
        logic [EW-1:0] sum;
        logic [EW-1:0] c;
        sum = lo + hi;
        c   = sum >> 1;
        if ($signed(hi - lo) < $signed(ONE_EW)) begin
            return {c - HALF_EW, c + HALF_EW};
        end
        return {lo, hi};
    endfunction

    // input register
    logic                      r_s1_v;
    logic                      r_s1_last;
    logic signed [FIRST_W-1:0] r_s1_first;
    logic [COL_W-1:0]          r_s1_lcol;
    logic [ALPHA_W-1:0]        r_s1_af;
    logic [ALPHA_W-1:0]        r_s1_al;
    logic [ALPHA_W-1:0]        r_s1_ap;
    logic [AREA_IN_W-1:0]      r_s1_area;
    logic [OUTLINE_IN_W-1:0]   r_s1_outl;

    // frame state
    logic [ROW_W-1:0]     r_row_cnt;
    logic                 r_seen;
    logic [ROW_W-1:0]     r_top_row;
    logic [ROW_W-1:0]     r_bot_row;
    logic [COL_W-1:0]     r_min_col;
    logic [COL_W-1:0]     r_max_col;
    logic [ALPHA_W-1:0]   r_left_a;
    logic [ALPHA_W-1:0]   r_right_a;
    logic [ALPHA_W-1:0]   r_top_a;
    logic [ALPHA_W-1:0]   r_bot_a;
    logic [AREA_W-1:0]    r_area;
    logic [OUTLINE_W-1:0] r_outl;

    // raw edge stage
    logic                 r_s2_v;
    logic                 r_s2_vis;
    logic [EW-1:0]        r_s2_left;
    logic [EW-1:0]        r_s2_right;
    logic [EW-1:0]        r_s2_top;
    logic [EW-1:0]        r_s2_bot;
    logic [AREA_W-1:0]    r_s2_area;
    logic [OUTLINE_W-1:0] r_s2_outl;

    // output register
    logic                 r_o_v;
    logic                 r_o_vis;
    logic [EDGE_W-1:0]    r_o_left;
    logic [EDGE_W-1:0]    r_o_right;
    logic [EDGE_W-1:0]    r_o_top;
    logic [EDGE_W-1:0]    r_o_bot;
    logic [AREA_W-1:0]    r_o_area;
    logic [OUTLINE_W-1:0] r_o_outl;

    // handshake
    logic out_free, s2_free, s1_go, s2_go, in_go;

    assign out_free        = !r_o_v || i_m_axis_tready;
    assign s2_free         = !r_s2_v || out_free;
    assign s1_go           = r_s1_v && (!r_s1_last || s2_free);
    assign s2_go           = r_s2_v && out_free;
    assign o_s_axis_tready = !r_s1_v || s1_go;
    assign in_go           = i_s_axis_tvalid && o_s_axis_tready;

    // next frame state from the registered row
    logic                 empty;
    logic [COL_W-1:0]     f_col, l_col;
    logic [ALPHA_W-1:0]   af, al, ap;
    logic [AREA_W:0]      area_sum;
    logic [OUTLINE_W:0]   outl_sum;
    logic [ROW_W-1:0]     n_row_cnt;
    logic                 n_seen;
    logic [ROW_W-1:0]     n_top_row, n_bot_row;
    logic [COL_W-1:0]     n_min_col, n_max_col;
    logic [ALPHA_W-1:0]   n_left_a, n_right_a, n_top_a, n_bot_a;
    logic [AREA_W-1:0]    n_area;
    logic [OUTLINE_W-1:0] n_outl;
    logic [EW-1:0]        n_left, n_right, n_top, n_bot;

    always_comb begin
        empty = r_s1_first[FIRST_W-1];
        f_col = clamp_col(r_s1_first[COL_W-1:0]);
        l_col = clamp_col(r_s1_lcol);
        af    = clamp_alpha(r_s1_af);
        al    = clamp_alpha(r_s1_al);
        ap    = clamp_alpha(r_s1_ap);

        area_sum = {1'b0, r_area} + (AREA_W + 1)'(r_s1_area);
        outl_sum = {1'b0, r_outl} + (OUTLINE_W + 1)'(r_s1_outl);
        // saturate at all ones
        n_area = area_sum[AREA_W] ? '1 : area_sum[AREA_W-1:0];
        n_outl = outl_sum[OUTLINE_W] ? '1 : outl_sum[OUTLINE_W-1:0];

        n_row_cnt = (r_row_cnt < ROW_LIMIT) ? r_row_cnt + 1'b1 : r_row_cnt;

        n_seen    = r_seen;
        n_top_row = r_top_row;
        n_bot_row = r_bot_row;
        n_min_col = r_min_col;
        n_max_col = r_max_col;
        n_left_a  = r_left_a;
        n_right_a = r_right_a;
        n_top_a   = r_top_a;
        n_bot_a   = r_bot_a;
        if (!empty) begin
            if (!r_seen) begin
                n_seen    = 1'b1;
                n_top_row = r_row_cnt;
                n_top_a   = ap;
                n_min_col = f_col;
                n_max_col = l_col;
                n_left_a  = af;
                n_right_a = al;
            end else begin
                if (f_col < r_min_col) begin
                    n_min_col = f_col;
                    n_left_a  = af;
                end else if (f_col == r_min_col && af > r_left_a) begin
                    n_left_a = af;
                end
                if (l_col > r_max_col) begin
                    n_max_col = l_col;
                    n_right_a = al;
                end else if (l_col == r_max_col && al > r_right_a) begin
                    n_right_a = al;
                end
            end
            n_bot_row = r_row_cnt;
            n_bot_a   = ap;
        end

        n_left  = EW'({n_min_col, FRAC_BITS'(0)}) + ONE_EW - EW'(n_left_a);
        n_right = EW'({n_max_col, FRAC_BITS'(0)}) + EW'(n_right_a);
        n_top   = EW'({n_top_row, FRAC_BITS'(0)}) + ONE_EW - EW'(n_top_a);
        n_bot   = EW'({n_bot_row, FRAC_BITS'(0)}) + EW'(n_bot_a);
    end

    // widening stage
    logic [2*EW-1:0] lr_w, tb_w;

    always_comb begin
        lr_w = widen(r_s2_left, r_s2_right);
        tb_w = widen(r_s2_top, r_s2_bot);
    end

    // control and frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_o_v     <= 1'b0;
            r_row_cnt <= '0;
            r_seen    <= 1'b0;
            r_top_row <= '0;
            r_bot_row <= '0;
            r_min_col <= '0;
            r_max_col <= '0;
            r_left_a  <= '0;
            r_right_a <= '0;
            r_top_a   <= '0;
            r_bot_a   <= '0;
            r_area    <= '0;
            r_outl    <= '0;
        end else begin
            if (in_go) begin
                r_s1_v <= 1'b1;
            end else if (s1_go) begin
                r_s1_v <= 1'b0;
            end

            if (s1_go && r_s1_last) begin
                r_s2_v <= 1'b1;
            end else if (s2_go) begin
                r_s2_v <= 1'b0;
            end

            if (s2_go) begin
                r_o_v <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_v <= 1'b0;
            end

            if (s1_go) begin
                if (r_s1_last) begin
                    // frame closes: start afresh
                    r_row_cnt <= '0;
                    r_seen    <= 1'b0;
                    r_top_row <= '0;
                    r_bot_row <= '0;
                    r_min_col <= '0;
                    r_max_col <= '0;
                    r_left_a  <= '0;
                    r_right_a <= '0;
                    r_top_a   <= '0;
                    r_bot_a   <= '0;
                    r_area    <= '0;
                    r_outl    <= '0;
                end else begin
                    r_row_cnt <= n_row_cnt;
                    r_seen    <= n_seen;
                    r_top_row <= n_top_row;
                    r_bot_row <= n_bot_row;
                    r_min_col <= n_min_col;
                    r_max_col <= n_max_col;
                    r_left_a  <= n_left_a;
                    r_right_a <= n_right_a;
                    r_top_a   <= n_top_a;
                    r_bot_a   <= n_bot_a;
                    r_area    <= n_area;
                    r_outl    <= n_outl;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_s1_last  <= i_s_axis_tlast;
            r_s1_first <= i_s_axis_tdata[IN_FIRST_LSB +: FIRST_W];
            r_s1_lcol  <= i_s_axis_tdata[IN_LAST_LSB +: COL_W];
            r_s1_af    <= i_s_axis_tdata[IN_AF_LSB +: ALPHA_W];
            r_s1_al    <= i_s_axis_tdata[IN_AL_LSB +: ALPHA_W];
            r_s1_ap    <= i_s_axis_tdata[IN_AP_LSB +: ALPHA_W];
            r_s1_area  <= i_s_axis_tdata[IN_AREA_LSB +: AREA_IN_W];
            r_s1_outl  <= i_s_axis_tdata[IN_OUTL_LSB +: OUTLINE_IN_W];
        end
        if (s1_go && r_s1_last) begin
            r_s2_vis   <= n_seen;
            r_s2_left  <= n_left;
            r_s2_right <= n_right;
            r_s2_top   <= n_top;
            r_s2_bot   <= n_bot;
            r_s2_area  <= n_area;
            r_s2_outl  <= n_outl;
        end
        if (s2_go) begin
            r_o_vis  <= r_s2_vis;
            r_o_area <= r_s2_area;
            r_o_outl <= r_s2_outl;
            if (r_s2_vis) begin
                r_o_left  <= lr_w[EW +: EDGE_W];
                r_o_right <= lr_w[0 +: EDGE_W];
                r_o_top   <= tb_w[EW +: EDGE_W];
                r_o_bot   <= tb_w[0 +: EDGE_W];
            end else begin
                r_o_left  <= '0;
                r_o_right <= '0;
                r_o_top   <= '0;
                r_o_bot   <= '0;
            end
        end
    end

    assign o_m_axis_tvalid = r_o_v;
    assign o_m_axis_tuser  = OUT_USER_W'(r_o_vis);
    assign o_m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), r_o_outl, r_o_area,
                              r_o_bot, r_o_top, r_o_right, r_o_left};

endmodule

>>> hdl/asbm_checker.sv
// Port-level checker for alpha_shape_bounds_measure, bound to the top level.
// Depends on asbm_pkg and alpha_shape_bounds_measure_macros.svh.
`include "alpha_shape_bounds_measure_macros.svh"

module asbm_checker
    import asbm_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // edges, totals, pad
    input logic [OUT_USER_W-1:0]  o_m_axis_tuser    // visible
);

    localparam logic signed [EDGE_W:0] ONE_SPAN = (EDGE_W + 1)'(ONE_FX);

    logic signed [EDGE_W:0]              left_x, right_x, span;
    logic                                edges_zero;
    logic                                out_stall;
    logic                                out_vis;
    logic                                out_invis;
    logic [OUT_USER_W+OUT_TDATA_W-1:0]   out_word;

    assign left_x     = {o_m_axis_tdata[OUT_RIGHT_LSB-1],
                         o_m_axis_tdata[OUT_LEFT_LSB +: EDGE_W]};
    assign right_x    = {o_m_axis_tdata[OUT_TOP_LSB-1],
                         o_m_axis_tdata[OUT_RIGHT_LSB +: EDGE_W]};
    assign span       = right_x - left_x;
    assign edges_zero = (o_m_axis_tdata[OUT_AREA_LSB-1:0] == '0);
    assign out_stall  = o_m_axis_tvalid && !i_m_axis_tready;
    assign out_vis    = o_m_axis_tvalid && o_m_axis_tuser[0];
    assign out_invis  = o_m_axis_tvalid && !o_m_axis_tuser[0];
    assign out_word   = {o_m_axis_tuser, o_m_axis_tdata};

    // a waiting result stays put
    `ASBM_ASSERT(a_out_hold, i_clk, i_rst_n, out_stall |=> o_m_axis_tvalid && $stable(out_word))
    // no result straight after reset
    `ASBM_ASSERT_NR(a_rst_idle, i_clk, !i_rst_n |=> !o_m_axis_tvalid)
    // empty output register never blocks the input
    `ASBM_ASSERT(a_ready_free, i_clk, i_rst_n, !o_m_axis_tvalid |-> o_s_axis_tready)
    // invisible frame carries zero edges
    `ASBM_ASSERT(a_invis_zero, i_clk, i_rst_n, out_invis |-> edges_zero)
    // horizontal span is at least one pixel
    `ASBM_ASSERT(a_min_span, i_clk, i_rst_n, out_vis |-> span >= ONE_SPAN)

endmodule

bind alpha_shape_bounds_measure asbm_checker u_asbm_checker (.*);
